// ===== src/fit_policy_block_allocator_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the fit-policy block allocator
// Concurrent check wrappers; they expand to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef FIT_POLICY_BLOCK_ALLOCATOR_CORE_MACROS_SVH
`define FIT_POLICY_BLOCK_ALLOCATOR_CORE_MACROS_SVH
`ifndef SYNTH
// Condition holds at every edge out of reset
`define FPBA_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// Consequent holds in the same cycle as the antecedent
`define FPBA_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Consequent holds in the cycle after the antecedent
`define FPBA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define FPBA_ASSERT_ALWAYS(lbl, clk, rst, cond, msg)
`define FPBA_ASSERT_SAME(lbl, clk, rst, ante, cons, msg)
`define FPBA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ===== src/fpba_pkg.sv =====
// ----------------------------------------------------------------------------
// fpba_pkg
// Shared widths, codes and controller/datapath types for the block allocator.
// ----------------------------------------------------------------------------
package fpba_pkg;

  // Default geometry
  localparam int NUM_BLOCKS_DEF = 16;
  localparam int SIZE_BITS_DEF  = 16;

  // Fixed field widths
  localparam int KIND_W    = 1;
  localparam int BIDX_W    = 4;
  localparam int SIZE_W    = 16;
  localparam int TOTAL_W   = 20;
  localparam int POLICY_W  = 2;
  localparam int BIU_W     = 5;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 5;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_LOAD  = 1'b0;
  localparam logic [KIND_W-1:0] KIND_ALLOC = 1'b1;

  // Fit policies; the unused code behaves as first fit
  localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
  localparam logic [POLICY_W-1:0] POL_BEST  = 2'd1;
  localparam logic [POLICY_W-1:0] POL_WORST = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_POLICY        = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_IN_USE = 1'd1;

  // Reset values of the registers
  localparam logic [POLICY_W-1:0] POLICY_RST = POL_FIRST;
  localparam logic [BIU_W-1:0]    BIU_RST    = 5'd16;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;   // latch the accepted item and arm the scan
    logic load_rd;   // read the old size of the block named by a load
    logic scan;      // step the search over the table
    logic commit;    // write back the table and the result register
  } fpba_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic scan_done; // every searched block has been read
    logic out_free;  // result register can take a new result
  } fpba_status_t;

endpackage

// ===== src/fpba_in_if.sv =====
// ----------------------------------------------------------------------------
// fpba_in_if
// Item channel: load or allocate request with valid/ready handshake.
// ----------------------------------------------------------------------------
interface fpba_in_if;
  import fpba_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [BIDX_W-1:0] block_index;
  logic [SIZE_W-1:0] size_value;

  modport source (output valid, kind, block_index, size_value, input ready);
  modport sink   (input valid, kind, block_index, size_value, output ready);
endinterface

// ===== src/fpba_out_if.sv =====
// ----------------------------------------------------------------------------
// fpba_out_if
// Result channel: grant, chosen block, remainder and total free space.
// ----------------------------------------------------------------------------
interface fpba_out_if;
  import fpba_pkg::*;

  logic               valid;
  logic               ready;
  logic               granted;
  logic [BIDX_W-1:0]  chosen_block;
  logic [SIZE_W-1:0]  remaining;
  logic [TOTAL_W-1:0] total_free;

  modport source (output valid, granted, chosen_block, remaining, total_free,
                  input ready);
  modport sink   (input valid, granted, chosen_block, remaining, total_free,
                  output ready);
endinterface

// ===== src/fpba_ctrl.sv =====
// ----------------------------------------------------------------------------
// fpba_ctrl
// Sequencer: accepts one item, runs the load read or the table scan, commits.
// ----------------------------------------------------------------------------
module fpba_ctrl
  import fpba_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [KIND_W-1:0] in_kind,
  output logic              in_ready,
  input  fpba_status_t      status,
  output fpba_cmd_t         cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD_RD,
    ST_SCAN,
    ST_FINISH
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  // Take no transfer while reset is asserted
  assign in_ready = (state == ST_IDLE) && !rst;
  assign accept   = in_valid && in_ready;

  // Decode commands and next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd.capture = 1'b1;
          state_next  = (in_kind == KIND_LOAD) ? ST_LOAD_RD : ST_SCAN;
        end
      end
      ST_LOAD_RD: begin
        cmd.load_rd = 1'b1;
        state_next  = ST_FINISH;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // hold until the result register drains
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== src/fpba_datapath.sv =====
// ----------------------------------------------------------------------------
// fpba_datapath
// Block size table, config registers, fit search, total and result register.
// ----------------------------------------------------------------------------
`include "fit_policy_block_allocator_core_macros.svh"

module fpba_datapath
  import fpba_pkg::*;
#(
  parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
  parameter int SIZE_BITS  = SIZE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  // item payload
  input  logic [KIND_W-1:0]    in_kind,
  input  logic [BIDX_W-1:0]    in_block_index,
  input  logic [SIZE_W-1:0]    in_size_value,
  // controller link
  input  fpba_cmd_t            cmd,
  output fpba_status_t         status,
  // result
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic                 out_granted,
  output logic [BIDX_W-1:0]    out_chosen_block,
  output logic [SIZE_W-1:0]    out_remaining,
  output logic [TOTAL_W-1:0]   out_total_free
);

  localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
  localparam int LIM_W = (CNT_W > BIU_W) ? CNT_W : BIU_W;

  // Configuration registers
  logic [POLICY_W-1:0]  policy;
  logic [BIU_W-1:0]     blocks_in_use;

  // Captured item
  logic [KIND_W-1:0]    req_kind;
  logic [BIDX_W-1:0]    req_idx;
  logic [SIZE_BITS-1:0] req_size;
  logic [LIM_W-1:0]     limit;

  // Scan state
  logic [LIM_W-1:0]     cnt;
  logic                 rd_pend;
  logic [IDX_W-1:0]     rd_idx;
  logic                 pick_vld;
  logic [IDX_W-1:0]     pick_idx;
  logic [SIZE_BITS-1:0] pick_size;

  // Table with its read port and its write port
  logic [SIZE_BITS-1:0] mem [NUM_BLOCKS];
  logic [NUM_BLOCKS-1:0] entry_vld;
  logic [SIZE_BITS-1:0] rd_data;
  logic                 rd_ok;
  logic                 rd_en;
  logic [IDX_W-1:0]     rd_addr;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  logic [SIZE_BITS-1:0] wr_data;

  logic [TOTAL_W-1:0]   total;

  logic [LIM_W-1:0]     biu_ext;
  logic                 scan_issue;
  logic [SIZE_BITS-1:0] cur_size;
  logic                 qual;
  logic                 take;
  logic                 load_hit;
  logic [SIZE_BITS-1:0] alloc_left;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      policy        <= POLICY_RST;
      blocks_in_use <= BIU_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_POLICY:        policy        <= cfg_data[POLICY_W-1:0];
        REG_BLOCKS_IN_USE: blocks_in_use <= cfg_data[BIU_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Widen the searched block count; it is saturated at the table depth on capture
  assign biu_ext = LIM_W'(blocks_in_use);

  // Latch the accepted item
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_kind <= in_kind;
      req_idx  <= in_block_index;
      req_size <= SIZE_BITS'(in_size_value);
    end
  end

  assign load_hit   = (32'(req_idx) < NUM_BLOCKS);
  assign scan_issue = cmd.scan && (cnt != limit);

  // Read port: load reads its block, scan reads the counter address
  assign rd_en   = (cmd.load_rd && load_hit) || scan_issue;
  assign rd_addr = cmd.load_rd ? IDX_W'(req_idx) : cnt[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
      rd_ok   <= entry_vld[rd_addr];
    end
  end

  // Entries never written read as zero
  assign cur_size = rd_ok ? rd_data : '0;

  // Fit decision for the entry coming out of the read port
  assign qual = (cur_size >= req_size);
  always_comb begin
    take = 1'b0;
    if (qual) begin
      if (!pick_vld) begin
        take = 1'b1;
      end else if (policy == POL_BEST) begin
        take = (cur_size < pick_size);
      end else if (policy == POL_WORST) begin
        take = (cur_size > pick_size);
      end
    end
  end

  // Advance the scan and track the best candidate
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      limit    <= '0;
      rd_pend  <= 1'b0;
      pick_vld <= 1'b0;
    end else if (cmd.capture) begin
      cnt      <= '0;
      limit    <= (biu_ext > LIM_W'(NUM_BLOCKS)) ? LIM_W'(NUM_BLOCKS) : biu_ext;
      rd_pend  <= 1'b0;
      pick_vld <= 1'b0;
    end else begin
      rd_pend <= scan_issue;
      if (scan_issue) begin
        cnt <= cnt + 1'b1;
      end
      if (rd_pend && take) begin
        pick_vld <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (scan_issue) begin
      rd_idx <= cnt[IDX_W-1:0];
    end
    if (rd_pend && take) begin
      pick_idx  <= rd_idx;
      pick_size <= cur_size;
    end
  end

  assign status.scan_done = (cnt == limit);
  assign status.out_free  = !out_valid || out_ready;

  // Write port: commit of a load or of a granted allocate
  assign alloc_left = pick_size - req_size;
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pick_idx;
    wr_data = alloc_left;
    if (cmd.commit) begin
      if (req_kind == KIND_LOAD) begin
        wr_en   = load_hit;
        wr_addr = IDX_W'(req_idx);
        wr_data = req_size;
      end else begin
        wr_en = pick_vld;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_vld <= '0;
    end else if (wr_en) begin
      entry_vld[wr_addr] <= 1'b1;
    end
  end

  // Update total free space
  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
    end else if (cmd.commit) begin
      if (req_kind == KIND_LOAD) begin
        if (load_hit) begin
          total <= total - TOTAL_W'(cur_size) + TOTAL_W'(req_size);
        end
      end else if (pick_vld) begin
        total <= total - TOTAL_W'(req_size);
      end
    end
  end

  // Result register; a new item may run while a result waits here
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (req_kind == KIND_LOAD) begin
        out_granted      <= 1'b0;
        out_chosen_block <= req_idx;
        out_remaining    <= load_hit ? SIZE_W'(req_size) : '0;
        out_total_free   <= load_hit ?
                            (total - TOTAL_W'(cur_size) + TOTAL_W'(req_size)) : total;
      end else begin
        out_granted      <= pick_vld;
        out_chosen_block <= pick_vld ? BIDX_W'(pick_idx) : '0;
        out_remaining    <= pick_vld ? SIZE_W'(alloc_left) : '0;
        out_total_free   <= pick_vld ? (total - TOTAL_W'(req_size)) : total;
      end
    end
  end

  // Checks
  `FPBA_ASSERT_ALWAYS(a_cnt_in_limit, clk, rst, cnt <= limit, "scan counter passed limit")
  `FPBA_ASSERT_SAME(a_commit_free, clk, rst, cmd.commit, !out_valid || out_ready, "commit over full result")
  `FPBA_ASSERT_NEXT(a_commit_shows, clk, rst, cmd.commit, out_valid, "commit lost its result")
  `FPBA_ASSERT_ALWAYS(a_pick_fits, clk, rst, !pick_vld || (pick_size >= req_size), "pick too small")

endmodule

// ===== src/fit_policy_block_allocator_core.sv =====
// ----------------------------------------------------------------------------
// fit_policy_block_allocator_core
// First, best or worst fit allocator over a table of block free sizes.
// ----------------------------------------------------------------------------
//   channel  dir  handshake     payload
//   item     in   valid/ready   kind, block_index, size_value
//   result   out  valid/ready   granted, chosen_block, remaining, total_free
//   cfg      in   cfg_we        cfg_index, cfg_data (write only)
//
// A load commits after its transfer and one read of its block. An allocate
// commits after L = min(blocks_in_use, NUM_BLOCKS) reads, one table read per
// cycle on the read port of the size table, once the last read data is in.
// The result is offered and the next item is taken from the cycle after commit.
// A stalled result register holds the finished item in its commit step.
// Reset (rst, synchronous) clears the table valid bits, total and registers.
// ----------------------------------------------------------------------------
module fit_policy_block_allocator_core
  import fpba_pkg::*;
#(
  parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
  parameter int SIZE_BITS  = SIZE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  fpba_in_if.sink              item,
  fpba_out_if.source           result
);

  fpba_cmd_t    cmd;
  fpba_status_t status;

  // Sequence one item at a time
  fpba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_kind  (item.kind),
    .in_ready (item.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Table, search and result register
  fpba_datapath #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .SIZE_BITS  (SIZE_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_kind          (item.kind),
    .in_block_index   (item.block_index),
    .in_size_value    (item.size_value),
    .cmd              (cmd),
    .status           (status),
    .out_ready        (result.ready),
    .out_valid        (result.valid),
    .out_granted      (result.granted),
    .out_chosen_block (result.chosen_block),
    .out_remaining    (result.remaining),
    .out_total_free   (result.total_free)
  );

endmodule

// ===== verif/fit_policy_block_allocator_core_tb.sv =====
// ----------------------------------------------------------------------------
// fit_policy_block_allocator_core_tb
// Drives load and allocate transfers into the allocator under every fit policy
// and several search widths, with a randomly stalling result side. A
// scoreboard keeps its own copy of the size table and the total, works out
// the result of each accepted item, and compares it with the block's result
// field by field.
// ----------------------------------------------------------------------------
module fit_policy_block_allocator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fpba_pkg::*;

  localparam int ITEM_TARGET  = 1850;
  localparam int STALL_LIMIT  = 4000;
  localparam int LONG_HOLD    = 400;
  localparam int HOLD_SPACING = 500;
  localparam logic [POLICY_W-1:0] POL_SPARE = 2'd3;
  localparam logic [SIZE_W-1:0]   SIZE_FULL = '1;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BIDX_W-1:0] block_index;
    logic [SIZE_W-1:0] size_value;
  } request_t;

  typedef struct packed {
    logic               granted;
    logic [BIDX_W-1:0]  chosen_block;
    logic [SIZE_W-1:0]  remaining;
    logic [TOTAL_W-1:0] total_free;
  } outcome_t;

  // Scoreboard: shadow size table, total and registers, plus results in flight
  class alloc_ledger;
    logic [SIZE_W-1:0]  free_size [NUM_BLOCKS_DEF];
    logic [TOTAL_W-1:0] free_sum;
    logic [POLICY_W-1:0] policy;
    logic [BIU_W-1:0]   blocks_in_use;
    outcome_t           pending[$];
    int                 errors;

    function void clear();
      foreach (free_size[i]) free_size[i] = '0;
      free_sum      = '0;
      policy        = POLICY_RST;
      blocks_in_use = BIU_RST;
      errors        = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      if (idx == REG_POLICY) begin
        policy = data[POLICY_W-1:0];
      end else if (idx == REG_BLOCKS_IN_USE) begin
        blocks_in_use = data[BIU_W-1:0];
      end
    endfunction

    function int search_width();
      return (blocks_in_use > NUM_BLOCKS_DEF) ? NUM_BLOCKS_DEF : int'(blocks_in_use);
    endfunction

    // Pick a block under the current policy; lowest index wins ties
    function int find_fit(logic [SIZE_W-1:0] req);
      int pick;
      int lim;
      pick = -1;
      lim  = search_width();
      for (int j = 0; j < lim; j++) begin
        if (free_size[j] < req) continue;
        if (pick < 0) begin
          pick = j;
          if (policy != POL_BEST && policy != POL_WORST) break;
        end else if (policy == POL_BEST && free_size[j] < free_size[pick]) begin
          pick = j;
        end else if (policy == POL_WORST && free_size[j] > free_size[pick]) begin
          pick = j;
        end
      end
      return pick;
    endfunction

    // Apply one accepted item to the shadow state and queue its result
    function void note_item(request_t req);
      outcome_t res;
      int       pick;
      res = '0;
      if (req.kind == KIND_LOAD) begin
        free_sum = free_sum - TOTAL_W'(free_size[req.block_index])
                   + TOTAL_W'(req.size_value);
        free_size[req.block_index] = req.size_value;
        res.chosen_block = req.block_index;
        res.remaining    = req.size_value;
      end else begin
        pick = find_fit(req.size_value);
        if (pick >= 0) begin
          free_size[pick]  = free_size[pick] - req.size_value;
          free_sum         = free_sum - TOTAL_W'(req.size_value);
          res.granted      = 1'b1;
          res.chosen_block = BIDX_W'(pick);
          res.remaining    = free_size[pick];
        end
      end
      res.total_free = free_sum;
      pending.push_back(res);
    endfunction

    function void report(string field, logic [TOTAL_W-1:0] want, logic [TOTAL_W-1:0] got);
      errors++;
      $display("[%0t] %s mismatch: expected %0d, actual %0d", $time, field, want, got);
    endfunction

    // Compare one result transfer with the oldest outstanding expectation
    function void check_result(outcome_t got);
      outcome_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("[%0t] unexpected result: expected none, actual %h", $time, got);
        return;
      end
      want = pending.pop_front();
      if (got.granted !== want.granted)
        report("granted", TOTAL_W'(want.granted), TOTAL_W'(got.granted));
      if (got.chosen_block !== want.chosen_block)
        report("chosen_block", TOTAL_W'(want.chosen_block), TOTAL_W'(got.chosen_block));
      if (got.remaining !== want.remaining)
        report("remaining", TOTAL_W'(want.remaining), TOTAL_W'(got.remaining));
      if (got.total_free !== want.total_free)
        report("total_free", want.total_free, got.total_free);
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  fpba_in_if  item_ch();
  fpba_out_if result_ch();

  fit_policy_block_allocator_core u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item_ch),
    .result    (result_ch)
  );

  alloc_ledger ledger;
  int          items_sent;
  int          results_seen;
  int          quiet_cycles;
  int          burst_left;
  int          hold_left;
  int          holds_taken;
  int unsigned stall_tick;
  int unsigned stall_pcts [4] = '{0, 20, 55, 85};

  always #10 clk = ~clk;

  // Check every result transfer
  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      ledger.check_result('{result_ch.granted, result_ch.chosen_block,
                            result_ch.remaining, result_ch.total_free});
      results_seen++;
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: cycle through stall levels, with two long hold-offs
  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rst) begin
        result_ch.ready = 1'b0;
      end else if (hold_left != 0) begin
        result_ch.ready = 1'b0;
        hold_left--;
      end else if (holds_taken < 2 && results_seen >= (holds_taken + 1) * HOLD_SPACING) begin
        hold_left = LONG_HOLD - 1;
        holds_taken++;
        result_ch.ready = 1'b0;
      end else begin
        stall_tick++;
        result_ch.ready = ($urandom_range(0, 99) >= stall_pcts[(stall_tick / 250) % 4]);
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_we = 1'b0;
    ledger.write_reg(idx, data);
  endtask

  // Offer one item and hold it until the transfer happens
  task automatic offer_item(input request_t req);
    @(negedge clk);
    item_ch.valid       = 1'b1;
    item_ch.kind        = req.kind;
    item_ch.block_index = req.block_index;
    item_ch.size_value  = req.size_value;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    ledger.note_item(req);
    items_sent++;
  endtask

  task automatic pause_sender(input int cycles);
    if (cycles == 0) return;
    @(negedge clk);
    item_ch.valid = 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Drop valid and wait until every outstanding result has come back
  task automatic settle();
    @(negedge clk);
    item_ch.valid = 1'b0;
    while (ledger.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Random item, biased toward requests that fit or just miss a live block
  function automatic request_t draw_request();
    request_t          req;
    int unsigned       pick;
    int                lim;
    logic [SIZE_W-1:0] base;
    lim = ledger.search_width();
    if (lim == 0) lim = 1;
    base = ledger.free_size[$urandom_range(0, lim - 1)];
    req.block_index = BIDX_W'($urandom_range(0, NUM_BLOCKS_DEF - 1));
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      req.kind = KIND_LOAD;
      pick = $urandom_range(0, 99);
      if (pick < 40)      req.size_value = SIZE_W'($urandom_range(0, 300));
      else if (pick < 60) req.size_value = SIZE_W'($urandom_range(0, 4095));
      else if (pick < 75) req.size_value = SIZE_W'($urandom_range(0, SIZE_FULL));
      else if (pick < 90) req.size_value = base;
      else begin
        case ($urandom_range(0, 3))
          0:       req.size_value = '0;
          1:       req.size_value = SIZE_FULL;
          2:       req.size_value = SIZE_W'(16'h8000);
          default: req.size_value = SIZE_W'(16'h7FFF);
        endcase
      end
    end else begin
      req.kind = KIND_ALLOC;
      pick = $urandom_range(0, 99);
      if (pick < 35)      req.size_value = base;
      else if (pick < 55) req.size_value = (base > 20) ? base - SIZE_W'($urandom_range(1, 20)) : base;
      else if (pick < 70) req.size_value = SIZE_W'($urandom_range(0, 60));
      else if (pick < 80) req.size_value = SIZE_W'($urandom_range(0, SIZE_FULL));
      else if (pick < 88) req.size_value = '0;
      else if (pick < 95) req.size_value = base + 1'b1;
      else                req.size_value = SIZE_FULL;
    end
    return req;
  endfunction

  initial begin
    int                  phase;
    int                  phase_items;
    logic [POLICY_W-1:0] pol;
    logic [BIU_W-1:0]    biu;

    clk                 = 1'b0;
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_index           = REG_POLICY;
    cfg_data            = '0;
    item_ch.valid       = 1'b0;
    item_ch.kind        = KIND_LOAD;
    item_ch.block_index = '0;
    item_ch.size_value  = '0;
    ledger = new;
    ledger.clear();

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Empty table: zero-size request is granted, anything larger is refused
    offer_item('{KIND_ALLOC, 4'd0, 16'd0});
    offer_item('{KIND_ALLOC, 4'd7, 16'd1});
    offer_item('{KIND_LOAD, 4'd0, SIZE_FULL});
    offer_item('{KIND_LOAD, 4'd15, SIZE_FULL});
    offer_item('{KIND_LOAD, 4'd3, 16'd100});
    offer_item('{KIND_LOAD, 4'd9, 16'd100});
    offer_item('{KIND_LOAD, 4'd6, 16'd40});
    offer_item('{KIND_LOAD, 4'd12, 16'd70});
    // First fit drains the two full blocks in order, refuses a third, then fits 30 in block 3
    offer_item('{KIND_ALLOC, 4'd0, SIZE_FULL});
    offer_item('{KIND_ALLOC, 4'd0, SIZE_FULL});
    offer_item('{KIND_ALLOC, 4'd0, SIZE_FULL});
    offer_item('{KIND_ALLOC, 4'd0, 16'd30});

    // Best fit, exact fit and a tie
    settle();
    write_reg(REG_POLICY, {3'b000, POL_BEST});
    offer_item('{KIND_ALLOC, 4'd0, 16'd40});
    offer_item('{KIND_ALLOC, 4'd0, 16'd70});

    // Worst fit and a tie
    settle();
    write_reg(REG_POLICY, {3'b101, POL_WORST});
    offer_item('{KIND_ALLOC, 4'd0, 16'd1});
    offer_item('{KIND_LOAD, 4'd4, 16'd99});
    offer_item('{KIND_ALLOC, 4'd0, 16'd5});

    // Unused policy code falls back to first fit
    settle();
    write_reg(REG_POLICY, {3'b111, POL_SPARE});
    offer_item('{KIND_ALLOC, 4'd0, 16'd10});

    // No block searched: every request refused
    settle();
    write_reg(REG_BLOCKS_IN_USE, 5'd0);
    offer_item('{KIND_ALLOC, 4'd0, 16'd0});

    // Search width above the table size saturates
    settle();
    write_reg(REG_BLOCKS_IN_USE, 5'd31);
    offer_item('{KIND_LOAD, 4'd15, 16'd500});
    offer_item('{KIND_ALLOC, 4'd0, 16'd400});

    // Single block searched
    settle();
    write_reg(REG_BLOCKS_IN_USE, 5'd1);
    offer_item('{KIND_ALLOC, 4'd0, 16'd0});

    // Random phases, each with its own policy and search width
    phase = 0;
    burst_left = 0;
    while (items_sent < ITEM_TARGET) begin
      settle();
      pol = (phase < 4) ? POLICY_W'(phase) : POLICY_W'($urandom_range(0, 3));
      case (phase)
        0:       biu = BIU_RST;
        1:       biu = 5'd1;
        2:       biu = 5'd31;
        3:       biu = 5'd0;
        4:       biu = 5'd2;
        5:       biu = 5'd17;
        default: begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: biu = BIU_RST;
            6, 7:             biu = BIU_W'($urandom_range(1, 15));
            8:                biu = BIU_W'($urandom_range(17, 31));
            default:          biu = 5'd0;
          endcase
        end
      endcase
      write_reg(REG_POLICY, {3'($urandom_range(0, 7)), pol});
      write_reg(REG_BLOCKS_IN_USE, biu);
      phase_items = (biu == 0) ? 40 : $urandom_range(120, 240);
      // Stop the last phase at the item target
      if (phase_items > ITEM_TARGET - items_sent) begin
        phase_items = ITEM_TARGET - items_sent;
      end
      repeat (phase_items) begin
        // Bursts of back-to-back items separated by idle gaps
        if (burst_left == 0) begin
          pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
          burst_left = $urandom_range(1, 40);
        end
        offer_item(draw_request());
        burst_left--;
      end
      phase++;
    end

    settle();
    repeat (40) @(posedge clk);
    if (ledger.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
